@@ hdl/balu_pkg.sv @@
// Shared types and constants for the byte ALU with BCD and flags.
package balu_pkg;

  // Operation codes carried in the slave-side tuser
  typedef enum logic [3:0] {
    OP_ADC  = 4'd0,
    OP_SBC  = 4'd1,
    OP_AND  = 4'd2,
    OP_OR   = 4'd3,
    OP_XOR  = 4'd4,
    OP_ASL  = 4'd5,
    OP_LSR  = 4'd6,
    OP_ROL  = 4'd7,
    OP_ROR  = 4'd8,
    OP_CMP  = 4'd9,
    OP_BIT  = 4'd10,
    OP_INC  = 4'd11,
    OP_DEC  = 4'd12,
    OP_LOAD = 4'd13
  } balu_op_t;

  // BCD digit limits and correction terms
  localparam logic [5:0] BCD_DIGIT_MAX = 6'd9;
  localparam logic [5:0] BCD_FIX_DIGIT = 6'd6;
  localparam logic [5:0] NIBBLE_MAX    = 6'd15;
  localparam logic [9:0] BCD_FIX_HIGH  = 10'h060;

  // One operation as held in the input register
  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic       carry_in;
    logic       overflow_in;
    logic       decimal_flag;
  } balu_req_t;

  // One result as held in the output register
  typedef struct packed {
    logic [7:0] result;
    logic       negative;
    logic       zero;
    logic       carry_out;
    logic       overflow_out;
  } balu_res_t;

endpackage

@@ hdl/balu_core.sv @@
// Combinational datapath of the byte ALU: result byte and new N, Z, C, V flags.
module balu_core
  import balu_pkg::*;
(
  input  balu_req_t req,
  output balu_res_t res
);

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] nb;
  logic [8:0] add_sum;
  logic [8:0] sub_sum;
  logic [8:0] cmp_diff;
  logic       add_v;
  logic       sub_v;
  logic [5:0] dadd_lo;
  logic [5:0] dadd_lo_fix;
  logic [5:0] dadd_hi;
  logic [5:0] dadd_hi_fix;
  logic [5:0] dsub_lo;
  logic [5:0] dsub_lo_m6;
  logic [5:0] dsub_lo_fix;
  logic [9:0] dsub_hi;
  logic [9:0] dsub_hi_fix;
  logic [7:0] r;
  logic       nz_from_r;

  assign a  = req.operand_a;
  assign b  = req.operand_b;
  assign nb = ~b;

  // Binary add and subtract; N, Z, V always come from these
  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, req.carry_in};
  assign sub_sum  = {1'b0, a} + {1'b0, nb} + {8'd0, req.carry_in};
  assign cmp_diff = {1'b0, a} - {1'b0, b};
  assign add_v    = (a[7] ^ add_sum[7]) & (b[7] ^ add_sum[7]);
  assign sub_v    = (a[7] ^ sub_sum[7]) & (nb[7] ^ sub_sum[7]);

  // Decimal add: correct each digit above nine
  assign dadd_lo     = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'd0, req.carry_in};
  assign dadd_lo_fix = (dadd_lo > BCD_DIGIT_MAX) ? dadd_lo + BCD_FIX_DIGIT : dadd_lo;
  assign dadd_hi     = {2'b00, a[7:4]} + {2'b00, b[7:4]}
                     + {5'd0, (dadd_lo_fix > NIBBLE_MAX)};
  assign dadd_hi_fix = (dadd_hi > BCD_DIGIT_MAX) ? dadd_hi + BCD_FIX_DIGIT : dadd_hi;

  // Decimal subtract: signed digit arithmetic, borrow correction on each digit
  assign dsub_lo     = {2'b00, a[3:0]} - {2'b00, b[3:0]} + {5'd0, req.carry_in} - 6'd1;
  assign dsub_lo_m6  = dsub_lo - BCD_FIX_DIGIT;
  assign dsub_lo_fix = dsub_lo[5] ? {2'b11, dsub_lo_m6[3:0]} : dsub_lo;
  assign dsub_hi     = {2'b00, a[7:4], 4'h0} - {2'b00, b[7:4], 4'h0}
                     + {{4{dsub_lo_fix[5]}}, dsub_lo_fix};
  assign dsub_hi_fix = dsub_hi[9] ? dsub_hi - BCD_FIX_HIGH : dsub_hi;

  // Select the result byte and flags per operation
  always_comb begin
    r                = a;
    nz_from_r        = 1'b1;
    res.result       = a;
    res.negative     = a[7];
    res.zero         = (a == 8'h00);
    res.carry_out    = req.carry_in;
    res.overflow_out = req.overflow_in;
    case (req.mode)
      OP_ADC: begin
        r                = add_sum[7:0];
        res.overflow_out = add_v;
        res.carry_out    = req.decimal_flag ? (dadd_hi_fix > NIBBLE_MAX) : add_sum[8];
      end
      OP_SBC: begin
        r                = sub_sum[7:0];
        res.overflow_out = sub_v;
        res.carry_out    = sub_sum[8];
      end
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_ASL: begin
        r             = {a[6:0], 1'b0};
        res.carry_out = a[7];
      end
      OP_LSR: begin
        r             = {1'b0, a[7:1]};
        res.carry_out = a[0];
      end
      OP_ROL: begin
        r             = {a[6:0], req.carry_in};
        res.carry_out = a[7];
      end
      OP_ROR: begin
        r             = {req.carry_in, a[7:1]};
        res.carry_out = a[0];
      end
      OP_CMP: begin
        r             = cmp_diff[7:0];
        res.carry_out = ~cmp_diff[8];
      end
      OP_BIT: begin
        r                = a & b;
        nz_from_r        = 1'b0;
        res.overflow_out = b[6];
      end
      OP_INC: r = a + 8'd1;
      OP_DEC: r = a - 8'd1;
      default: r = a;
    endcase

    // N and Z follow the binary byte; bit test takes N from the operand
    res.result   = r;
    res.zero     = (r == 8'h00);
    res.negative = nz_from_r ? r[7] : b[7];

    // Decimal mode replaces the result byte of add and subtract; the add carry comes from the decimal sum
    if (req.decimal_flag && (req.mode == OP_ADC)) begin
      res.result = {dadd_hi_fix[3:0], dadd_lo_fix[3:0]};
    end else if (req.decimal_flag && (req.mode == OP_SBC)) begin
      res.result = dsub_hi_fix[7:0];
    end
  end

endmodule

@@ hdl/byte_alu_with_bcd_and_flags.sv @@
// Top level of the byte ALU with BCD and flags: input register, datapath, result register.
//
// 6502-style byte ALU. Each slave-side transfer carries one operation in tuser and the
// operands and incoming C, V, D flags in tdata; each master-side transfer returns the
// result byte and the new N, Z, C, V flags. The block takes one transfer every cycle
// unless back-pressure fills both registers; each operation passes the input register,
// then the result register, with the whole ALU as one combinational pass between them.
// Both registers advance independently, so a new operation is taken while a finished
// result still waits on the master side; tready drops only when both hold data.
// Codes above load (14 and 15) behave as load.
module byte_alu_with_bcd_and_flags
  import balu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] operand_a, [15:8] operand_b, [16] carry_in, [17] overflow_in,
  // [18] decimal_flag, [23:19] zero
  input  logic [23:0] s_axis_tdata,
  // [3:0] mode
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] result, [8] negative, [9] zero, [10] carry_out, [11] overflow_out,
  // [15:12] zero
  output logic [15:0] m_axis_tdata
);

  logic      req_valid;
  balu_req_t req;
  balu_res_t res_comb;
  logic      res_valid;
  balu_res_t res;
  logic      res_free;

  // Result register can load when empty or being drained
  assign res_free      = ~res_valid | m_axis_tready;
  assign s_axis_tready = ~req_valid | res_free;

  // Input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid <= s_axis_tvalid;
    end
  end

  // Capture operation on transfer
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req.mode         <= s_axis_tuser;
      req.operand_a    <= s_axis_tdata[7:0];
      req.operand_b    <= s_axis_tdata[15:8];
      req.carry_in     <= s_axis_tdata[16];
      req.overflow_in  <= s_axis_tdata[17];
      req.decimal_flag <= s_axis_tdata[18];
    end
  end

  balu_core u_core (
    .req (req),
    .res (res_comb)
  );

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= req_valid;
    end
  end

  // Hold result until the master side takes it
  always_ff @(posedge clk) begin
    if (req_valid && res_free) begin
      res <= res_comb;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {4'h0, res.overflow_out, res.carry_out, res.zero,
                          res.negative, res.result};

endmodule
